>>> hdl/qse_pkg.sv
package qse_pkg;
    localparam int MAX_ITEMS  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int RANGE_W    = 2 * IDX_W;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [RANGE_W-1:0] range_t;
    typedef logic signed [DATA_WIDTH-1:0] data_t;
endpackage

>>> hdl/quicksort_engine.sv
// channel | ports                                   | direction
// s_      | s_valid s_ready s_value s_is_final       | item in, one element
// m_      | m_valid m_ready m_sorted_value m_end_of_set | item out, sorted element
//
// Loading writes each accepted item into the element RAM. After the final
// item (or a full store) the set is sorted by a quicksort sequencer built
// around one signed comparator and a simple dual-port element RAM (one read,
// one write per cycle), in roughly n*log2(n) compare steps on average and
// n^2/2 worst case. Emission reads each sorted item, holds it on the m_
// outputs until m_ready, and only then reads the next one.
// Reset (aresetn, synchronous, active low) clears the sequencer state, the load
// counter, the stack pointer and m_valid only; the RAMs hold garbage until written.
// s_ready is low from sort start until the last sorted item is taken.
module quicksort_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [qse_pkg::DATA_WIDTH-1:0] s_value,
    input  logic                                s_is_final,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [qse_pkg::DATA_WIDTH-1:0] m_sorted_value,
    output logic                                m_end_of_set
);
    typedef enum logic [3:0] {
        ST_LOAD, ST_INIT, ST_POP, ST_POP_WAIT, ST_PIVOT, ST_OUTER, ST_SCAN_I,
        ST_SCAN_J, ST_SWAP1, ST_SWAP2, ST_FIN_RD, ST_FIN_W2, ST_PUSH_B,
        ST_EM_RD, ST_EM_LD, ST_EM_WAIT
    } state_t;

    localparam int IW = qse_pkg::IDX_W;
    localparam int CW = qse_pkg::CNT_W;

    state_t          state_reg;
    qse_pkg::cnt_t   cnt_reg, n_reg, sp_reg;
    qse_pkg::idx_t   lo_reg, hi_reg, i_reg, j_reg, k_reg;
    qse_pkg::data_t  pivot_reg, vi_reg, vj_reg, rd_data_reg, out_data_reg;
    qse_pkg::range_t stk_rd_reg;
    logic            out_valid_reg, out_last_reg;

    // element store and range stack
    qse_pkg::data_t  mem [qse_pkg::MAX_ITEMS];
    qse_pkg::range_t stk [qse_pkg::MAX_ITEMS];

    logic            mem_we, stk_we;
    qse_pkg::idx_t   mem_waddr, mem_raddr, stk_waddr, stk_raddr;
    qse_pkg::data_t  mem_wdata;
    qse_pkg::range_t stk_wdata;
    logic            gt, i_adv, push1, push2, s_acc, full_hit;

    assign s_ready        = (state_reg == ST_LOAD);
    assign s_acc          = s_valid && s_ready;
    assign m_valid        = out_valid_reg;
    assign m_sorted_value = out_data_reg;
    assign m_end_of_set   = out_last_reg;

    assign gt       = rd_data_reg > pivot_reg;
    assign i_adv    = !gt && (i_reg < hi_reg);
    assign full_hit = (cnt_reg + CW'(1)) == CW'(qse_pkg::MAX_ITEMS);
    assign push1    = ({1'b0, j_reg} + CW'(1) < {1'b0, hi_reg})
                      && (sp_reg < CW'(qse_pkg::MAX_ITEMS));
    assign push2    = ({1'b0, lo_reg} + CW'(1) < {1'b0, j_reg});

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[IW-1:0];
        mem_wdata = s_value;
        mem_raddr = lo_reg;
        stk_we    = 1'b0;
        stk_waddr = sp_reg[IW-1:0];
        stk_wdata = {lo_reg, IW'(j_reg - IW'(1))};
        stk_raddr = IW'(sp_reg - CW'(1));
        case (state_reg)
            ST_LOAD: begin
                mem_we = s_acc;
            end
            ST_INIT: begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = {IW'(0), IW'(n_reg - CW'(1))};
            end
            ST_POP_WAIT: mem_raddr = stk_rd_reg[2*IW-1:IW];
            ST_OUTER:    mem_raddr = (i_reg < j_reg) ? i_reg : j_reg;
            ST_SCAN_I:   mem_raddr = i_adv ? IW'(i_reg + IW'(1)) : j_reg;
            ST_SCAN_J:   mem_raddr = IW'(j_reg - IW'(1));
            ST_SWAP1: begin
                mem_we = 1'b1; mem_waddr = i_reg; mem_wdata = vj_reg;
            end
            ST_SWAP2: begin
                mem_we = 1'b1; mem_waddr = j_reg; mem_wdata = vi_reg;
            end
            ST_FIN_RD: begin
                mem_we = 1'b1; mem_waddr = lo_reg; mem_wdata = rd_data_reg;
            end
            ST_FIN_W2: begin
                mem_we    = 1'b1; mem_waddr = j_reg; mem_wdata = pivot_reg;
                stk_we    = push1;
                stk_wdata = {IW'(j_reg + IW'(1)), hi_reg};
            end
            ST_PUSH_B: stk_we = push2;
            ST_EM_RD:  mem_raddr = k_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
        if (stk_we) stk[stk_waddr] <= stk_wdata;
        stk_rd_reg <= stk[stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_LOAD: if (s_acc) begin
                    cnt_reg <= cnt_reg + CW'(1);
                    n_reg   <= cnt_reg + CW'(1);
                    if (s_is_final || full_hit) state_reg <= ST_INIT;
                end
                ST_INIT: begin
                    sp_reg    <= (n_reg > CW'(1)) ? CW'(1) : CW'(0);
                    state_reg <= ST_POP;
                end
                ST_POP: begin
                    if (sp_reg == '0) begin
                        k_reg     <= '0;
                        state_reg <= ST_EM_RD;
                    end else begin
                        sp_reg    <= sp_reg - CW'(1);
                        state_reg <= ST_POP_WAIT;
                    end
                end
                ST_POP_WAIT: begin
                    lo_reg    <= stk_rd_reg[2*IW-1:IW];
                    i_reg     <= stk_rd_reg[2*IW-1:IW];
                    hi_reg    <= stk_rd_reg[IW-1:0];
                    j_reg     <= stk_rd_reg[IW-1:0];
                    state_reg <= ST_PIVOT;
                end
                ST_PIVOT: begin
                    pivot_reg <= rd_data_reg;
                    state_reg <= ST_OUTER;
                end
                ST_OUTER: state_reg <= (i_reg < j_reg) ? ST_SCAN_I : ST_FIN_RD;
                ST_SCAN_I: begin
                    if (i_adv) begin
                        i_reg <= i_reg + IW'(1);
                    end else begin
                        vi_reg    <= rd_data_reg;
                        state_reg <= ST_SCAN_J;
                    end
                end
                ST_SCAN_J: begin
                    // pivot sits at lo, so j never passes below lo
                    if (gt) begin
                        j_reg <= j_reg - IW'(1);
                    end else begin
                        vj_reg    <= rd_data_reg;
                        state_reg <= (i_reg < j_reg) ? ST_SWAP1 : ST_OUTER;
                    end
                end
                ST_SWAP1:  state_reg <= ST_SWAP2;
                ST_SWAP2:  state_reg <= ST_OUTER;
                ST_FIN_RD: state_reg <= ST_FIN_W2;
                ST_FIN_W2: begin
                    if (push1) sp_reg <= sp_reg + CW'(1);
                    state_reg <= ST_PUSH_B;
                end
                ST_PUSH_B: begin
                    if (push2) sp_reg <= sp_reg + CW'(1);
                    state_reg <= ST_POP;
                end
                ST_EM_RD: state_reg <= ST_EM_LD;
                ST_EM_LD: begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= rd_data_reg;
                    out_last_reg  <= ({1'b0, k_reg} + CW'(1)) == n_reg;
                    state_reg     <= ST_EM_WAIT;
                end
                ST_EM_WAIT: if (m_ready) begin
                    out_valid_reg <= 1'b0;
                    if (out_last_reg) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end else begin
                        k_reg     <= k_reg + IW'(1);
                        state_reg <= ST_EM_RD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input open while emitting");
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= CW'(qse_pkg::MAX_ITEMS)) else $error("range stack overflow");
    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_end_of_set) |=> s_ready)
        else $error("input not reopened after last item");
endmodule
